### hw/rtl/lcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_pkg: shared types, constants and tables of the Lab color distance block
// Holds the sRGB linearization table, the XYZ matrix, the divider constants
// and the rounding helper used by the Lab stages.
// ----------------------------------------------------------------------------
package lcd_pkg;

    // Default number of cube root table segments over [0, 1].
    localparam int CBRT_DEPTH_DEFAULT = 1024;

    // Width of one cube root table entry (values up to 65536).
    localparam int TBL_ENTRY_W = 17;

    // Pipeline length: color to Lab stages plus distance stages.
    localparam int LAB_STAGES = 13;
    localparam int DIST_STAGES = 3;
    localparam int PIPE_DEPTH = LAB_STAGES + DIST_STAGES;

    // Output field width and saturation value.
    localparam int DIST_W = 25;
    localparam logic [DIST_W-1:0] DIST_MAX = 25'd33554431;

    // sRGB to XYZ matrix in Q16, rows X, Y, Z.
    localparam logic [15:0] MAT_COEF [0:2][0:2] = '{
        '{16'd27027, 16'd23436, 16'd11829},
        '{16'd13933, 16'd46871, 16'd4732},
        '{16'd1265,  16'd7812,  16'd62292}
    };

    // White point scaling: X * 10000 / 9505 and Z * 1000 / 1089, rounded.
    localparam logic [13:0] XW_MUL = 14'd10000;
    localparam logic [12:0] XW_ADD = 13'd4752;
    localparam logic [13:0] XW_DIV = 14'd9505;
    localparam int          XW_SHIFT = 44;
    localparam logic [30:0] XW_RECIP = 31'((64'd1 << XW_SHIFT) / 64'd9505);

    localparam logic [9:0]  ZW_MUL = 10'd1000;
    localparam logic [9:0]  ZW_ADD = 10'd544;
    localparam logic [10:0] ZW_DIV = 11'd1089;
    localparam int          ZW_SHIFT = 41;
    localparam logic [30:0] ZW_RECIP = 31'((64'd1 << ZW_SHIFT) / 64'd1089);

    // Linear segment of f(t): (7787 * t + 500) / 1000 + 9039 for t <= 580.
    localparam logic [16:0] F_LIN_LIMIT = 17'd580;
    localparam logic [12:0] F_LIN_MUL = 13'd7787;
    localparam logic [8:0]  F_LIN_ADD = 9'd500;
    localparam logic [13:0] F_LIN_OFS = 14'd9039;
    localparam int          F_LIN_SHIFT = 33;
    localparam logic [23:0] F_LIN_RECIP = 24'd8589935;
    localparam logic [16:0] F_ONE = 17'd65536;

    // Cube root table fill controller states.
    typedef enum logic [0:0] {
        ST_FILL,
        ST_RUN
    } t_fill_state;

    typedef logic [15:0] t_lin_table [0:255];

    // Fifth power in Q30 with each product truncated.
    function automatic longint unsigned pow5_q30(input longint unsigned w);
        longint unsigned p;
        p = (w * w) >> 30;
        p = (p * w) >> 30;
        p = (p * w) >> 30;
        p = (p * w) >> 30;
        return p;
    endfunction

    // sRGB byte to linear Q0.16, evaluated once at elaboration.
    function automatic t_lin_table build_lin_table();
        t_lin_table tbl;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned y;
        longint unsigned r;
        for (int c = 0; c < 256; c++) begin
            if (longint'(c) * 100000 <= 1031475) begin
                tbl[c] = 16'((longint'(c) * 6553600 + 164730) / 329460);
            end else begin
                x = ((longint'(c) * 1000 + 14025) << 30) / 269025;
                x2 = (x * x) >> 30;
                lo = 0;
                hi = 64'd1 << 30;
                while (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    if (pow5_q30(mid) <= x2) begin
                        lo = mid;
                    end else begin
                        hi = mid - 1;
                    end
                end
                y = (x2 * lo) >> 30;
                r = (y + 8192) >> 14;
                tbl[c] = (r > 65535) ? 16'hFFFF : 16'(r);
            end
        end
        return tbl;
    endfunction

    localparam t_lin_table LIN_TABLE = build_lin_table();

    // Q8 to integer rounding, half away from zero, clamped to 16 bits.
    function automatic logic signed [15:0] round_q8(input logic signed [26:0] v);
        logic [26:0] mag;
        logic [19:0] r;
        logic signed [19:0] neg_r;
        mag = (v < 0) ? 27'(-v) : 27'(v);
        r = 20'((28'(mag) + 28'd128) >> 8);
        neg_r = -$signed(r);
        if (v >= 0) begin
            return (r > 20'd32767) ? 16'sd32767 : 16'(r);
        end else begin
            return (r > 20'd32768) ? -16'sd32768 : 16'(neg_r);
        end
    endfunction

endpackage
`default_nettype wire

### hw/rtl/lcd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_if: request and result channels of the Lab color distance block
// Each channel carries valid, ready and its payload fields.
// ----------------------------------------------------------------------------

// Request channel: two 8-bit RGB colors.
interface lcd_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_red;
    logic [7:0] left_green;
    logic [7:0] left_blue;
    logic [7:0] right_red;
    logic [7:0] right_green;
    logic [7:0] right_blue;

    modport source (
        output valid, left_red, left_green, left_blue,
        output right_red, right_green, right_blue,
        input  ready
    );
    modport sink (
        input  valid, left_red, left_green, left_blue,
        input  right_red, right_green, right_blue,
        output ready
    );
endinterface

// Result channel: squared Lab distance.
interface lcd_res_if;
    logic        valid;
    logic        ready;
    logic [24:0] distance_squared;

    modport source (
        output valid, distance_squared,
        input  ready
    );
    modport sink (
        input  valid, distance_squared,
        output ready
    );
endinterface
`default_nettype wire

### hw/rtl/lcd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_ram: generic single-write, single-read RAM
// One write port and one registered read port with read enable.
// ----------------------------------------------------------------------------
module lcd_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lcd_cbrt_fill.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_cbrt_fill: cube root table builder
// After reset it walks the table entries. Entry i is the integer cube root of
// floor(i * 2^48 / depth); the root and its cube are grown by adds only, one
// step per cycle. Each written word holds entry i and entry i + 1.
// ----------------------------------------------------------------------------
module lcd_cbrt_fill #(
    parameter int CUBE_ROOT_TABLE_DEPTH = lcd_pkg::CBRT_DEPTH_DEFAULT
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    output logic                                          o_done,
    output logic                                          o_wr_en,
    output logic [$clog2(CUBE_ROOT_TABLE_DEPTH)-1:0]      o_wr_addr,
    output logic [2*lcd_pkg::TBL_ENTRY_W-1:0]             o_wr_data
);

    localparam int IDX_W = $clog2(CUBE_ROOT_TABLE_DEPTH);
    localparam int CNT_W = $clog2(CUBE_ROOT_TABLE_DEPTH + 1);
    localparam int REM_W = $clog2(CUBE_ROOT_TABLE_DEPTH);
    localparam int EW = lcd_pkg::TBL_ENTRY_W;
    localparam logic [48:0] Q0 = 49'((64'd1 << 48) / CUBE_ROOT_TABLE_DEPTH);
    localparam logic [REM_W-1:0] R0 = REM_W'((64'd1 << 48) % CUBE_ROOT_TABLE_DEPTH);
    localparam logic [REM_W:0] DEPTH_W = (REM_W+1)'(CUBE_ROOT_TABLE_DEPTH);

    lcd_pkg::t_fill_state r_state, n_state;

    logic [CNT_W-1:0] r_idx, n_idx;
    logic [48:0]      r_target, n_target;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [EW-1:0]    r_root, n_root;
    logic [EW-1:0]    r_prev, n_prev;
    logic [49:0]      r_cube, n_cube;
    logic [34:0]      r_delta, n_delta;
    logic [19:0]      r_step, n_step;

    logic             grow;
    logic             last;
    logic [REM_W:0]   rem_sum;
    logic             carry;

    assign grow = (r_cube <= 50'(r_target));
    assign last = (r_idx == CNT_W'(CUBE_ROOT_TABLE_DEPTH));
    assign rem_sum = (REM_W+1)'(r_rem) + (REM_W+1)'(R0);
    assign carry = (rem_sum >= DEPTH_W);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lcd_pkg::ST_FILL: begin
                if (!grow && last) begin
                    n_state = lcd_pkg::ST_RUN;
                end
            end
            lcd_pkg::ST_RUN: n_state = lcd_pkg::ST_RUN;
            default: n_state = lcd_pkg::ST_FILL;
        endcase
    end

    // Outputs: a word is written once the root of the next entry is known.
    always_comb begin
        o_done = 1'b0;
        o_wr_en = 1'b0;
        case (r_state)
            lcd_pkg::ST_FILL: o_wr_en = !grow && (r_idx != '0);
            lcd_pkg::ST_RUN:  o_done = 1'b1;
            default: o_done = 1'b0;
        endcase
    end
    assign o_wr_addr = IDX_W'(r_idx - CNT_W'(1));
    assign o_wr_data = {r_prev, r_root};

    // Root search and target sweep.
    always_comb begin
        n_idx = r_idx;
        n_target = r_target;
        n_rem = r_rem;
        n_root = r_root;
        n_prev = r_prev;
        n_cube = r_cube;
        n_delta = r_delta;
        n_step = r_step;
        if (r_state == lcd_pkg::ST_FILL) begin
            if (grow) begin
                n_root = r_root + EW'(1);
                n_cube = r_cube + 50'(r_delta);
                n_delta = r_delta + 35'(r_step);
                n_step = r_step + 20'd6;
            end else if (!last) begin
                n_prev = r_root;
                n_idx = r_idx + CNT_W'(1);
                n_target = r_target + Q0 + 49'(carry);
                n_rem = carry ? REM_W'(rem_sum - DEPTH_W) : REM_W'(rem_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcd_pkg::ST_FILL;
            r_idx <= '0;
            r_target <= '0;
            r_rem <= '0;
            r_root <= '0;
            r_prev <= '0;
            r_cube <= 50'd1;
            r_delta <= 35'd7;
            r_step <= 20'd12;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_target <= n_target;
            r_rem <= n_rem;
            r_root <= n_root;
            r_prev <= n_prev;
            r_cube <= n_cube;
            r_delta <= n_delta;
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lcd_lab.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_lab: one color from sRGB bytes to L*, a*, b*
// Thirteen register stages: linearize, matrix products, matrix sums, white
// point scaling, f(t) in four stages, Lab scaling, rounding.
// ----------------------------------------------------------------------------
module lcd_lab #(
    parameter int CUBE_ROOT_TABLE_DEPTH = lcd_pkg::CBRT_DEPTH_DEFAULT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_ce,
    input  wire logic [7:0]                            i_red,
    input  wire logic [7:0]                            i_green,
    input  wire logic [7:0]                            i_blue,
    input  wire logic                                  i_wr_en,
    input  wire logic [$clog2(CUBE_ROOT_TABLE_DEPTH)-1:0] i_wr_addr,
    input  wire logic [2*lcd_pkg::TBL_ENTRY_W-1:0]     i_wr_data,
    output logic signed [15:0]                         o_lab [3]
);

    localparam int IDX_W = $clog2(CUBE_ROOT_TABLE_DEPTH);
    localparam int S_W = 16 + IDX_W;
    localparam int EW = lcd_pkg::TBL_ENTRY_W;

    logic [15:0]       r_lin [3];
    logic [31:0]       r_prod [3][3];
    logic [32:0]       n_sum [3];
    logic [15:0]       r_x3, r_y3;
    logic [16:0]       r_z3;
    logic [29:0]       r_xnum4, r_xnum5, r_xnum6;
    logic [26:0]       r_znum4, r_znum5, r_znum6;
    logic [15:0]       r_y4, r_y5, r_y6;
    logic [60:0]       r_xprod5;
    logic [57:0]       r_zprod5;
    logic [16:0]       q_x, q_z;
    logic [16:0]       r_xq6, r_zq6;
    logic [30:0]       r_xqd6;
    logic [27:0]       r_zqd6;
    logic [30:0]       rem_x;
    logic [27:0]       rem_z;
    logic [16:0]       r_t [3];

    logic [22:0]       r_nlow8 [3];
    logic              r_low8 [3], r_low9 [3], r_low10 [3];
    logic              r_sat8 [3], r_sat9 [3], r_sat10 [3];
    logic [S_W-1:0]    r_s8 [3];
    logic [15:0]       r_fr9 [3];
    logic [46:0]       r_qprod9 [3];
    logic [2*EW-1:0]   rd_data [3];
    logic [EW-1:0]     diff10 [3];
    logic [32:0]       r_dprod10 [3];
    logic [EW-1:0]     r_e010 [3];
    logic [EW-1:0]     r_flow10 [3];
    logic [17:0]       interp [3];
    logic [EW-1:0]     n_f [3];
    logic [EW-1:0]     r_f [3];

    logic signed [17:0] d_xy, d_yz;
    logic signed [24:0] r_lv;
    logic signed [26:0] r_av, r_bv;

    // Stage 1: sRGB curve by table lookup.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_lin[0] <= lcd_pkg::LIN_TABLE[i_red];
            r_lin[1] <= lcd_pkg::LIN_TABLE[i_green];
            r_lin[2] <= lcd_pkg::LIN_TABLE[i_blue];
        end
    end

    // Stage 2: the nine matrix products.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[k][j] <= 32'(r_lin[j]) * 32'(lcd_pkg::MAT_COEF[k][j]);
                end
            end
        end
    end

    // Stage 3: row sums rounded back to Q16.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = 33'(r_prod[k][0]) + 33'(r_prod[k][1]) + 33'(r_prod[k][2])
                     + 33'd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x3 <= n_sum[0][31:16];
            r_y3 <= n_sum[1][31:16];
            r_z3 <= n_sum[2][32:16];
        end
    end

    // Stage 4: white point numerators.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_xnum4 <= 30'(r_x3) * 30'(lcd_pkg::XW_MUL) + 30'(lcd_pkg::XW_ADD);
            r_znum4 <= 27'(r_z3) * 27'(lcd_pkg::ZW_MUL) + 27'(lcd_pkg::ZW_ADD);
            r_y4 <= r_y3;
        end
    end

    // Stage 5: multiply by the truncated reciprocal.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_xprod5 <= 61'(r_xnum4) * 61'(lcd_pkg::XW_RECIP);
            r_zprod5 <= 58'(r_znum4) * 58'(lcd_pkg::ZW_RECIP);
            r_xnum5 <= r_xnum4;
            r_znum5 <= r_znum4;
            r_y5 <= r_y4;
        end
    end

    // Stage 6: quotient estimate, which is low by at most one, and its product.
    assign q_x = r_xprod5[lcd_pkg::XW_SHIFT +: 17];
    assign q_z = r_zprod5[lcd_pkg::ZW_SHIFT +: 17];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_xq6 <= q_x;
            r_zq6 <= q_z;
            r_xqd6 <= 31'(q_x) * 31'(lcd_pkg::XW_DIV);
            r_zqd6 <= 28'(q_z) * 28'(lcd_pkg::ZW_DIV);
            r_xnum6 <= r_xnum5;
            r_znum6 <= r_znum5;
            r_y6 <= r_y5;
        end
    end

    // Stage 7: correct the quotient when the remainder reaches the divisor.
    assign rem_x = 31'(r_xnum6) - r_xqd6;
    assign rem_z = 28'(r_znum6) - r_zqd6;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_t[0] <= (rem_x >= 31'(lcd_pkg::XW_DIV)) ? r_xq6 + 17'd1 : r_xq6;
            r_t[1] <= 17'(r_y6);
            r_t[2] <= (rem_z >= 28'(lcd_pkg::ZW_DIV)) ? r_zq6 + 17'd1 : r_zq6;
        end
    end

    // Stage 8: f(t) setup, linear numerator and table position.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_nlow8[k] <= 23'(r_t[k][9:0]) * 23'(lcd_pkg::F_LIN_MUL)
                            + 23'(lcd_pkg::F_LIN_ADD);
                r_low8[k] <= (r_t[k] <= lcd_pkg::F_LIN_LIMIT);
                r_sat8[k] <= r_t[k][16];
                r_s8[k] <= S_W'(r_t[k][15:0]) * S_W'(CUBE_ROOT_TABLE_DEPTH);
            end
        end
    end

    // Stage 9: table read and division of the linear numerator by 1000.
    for (genvar k = 0; k < 3; k++) begin : g_tbl
        lcd_ram #(
            .WIDTH (2 * EW),
            .DEPTH (CUBE_ROOT_TABLE_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (i_wr_en),
            .i_wr_addr (i_wr_addr),
            .i_wr_data (i_wr_data),
            .i_rd_en   (i_ce),
            .i_rd_addr (r_s8[k][16 +: IDX_W]),
            .o_rd_data (rd_data[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_fr9[k] <= r_s8[k][15:0];
                r_qprod9[k] <= 47'(r_nlow8[k]) * 47'(lcd_pkg::F_LIN_RECIP);
                r_low9[k] <= r_low8[k];
                r_sat9[k] <= r_sat8[k];
            end
        end
    end

    // Stage 10: interpolation product and linear segment result.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff10[k] = rd_data[k][EW-1:0] - rd_data[k][2*EW-1:EW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_dprod10[k] <= 33'(diff10[k]) * 33'(r_fr9[k]);
                r_e010[k] <= rd_data[k][2*EW-1:EW];
                r_flow10[k] <= EW'(r_qprod9[k][46:lcd_pkg::F_LIN_SHIFT])
                             + EW'(lcd_pkg::F_LIN_OFS);
                r_low10[k] <= r_low9[k];
                r_sat10[k] <= r_sat9[k];
            end
        end
    end

    // Stage 11: pick the linear segment, the full-scale value or the cube root.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            interp[k] = 18'((r_dprod10[k] + 33'd32768) >> 16);
            if (r_low10[k]) begin
                n_f[k] = r_flow10[k];
            end else if (r_sat10[k]) begin
                n_f[k] = lcd_pkg::F_ONE;
            end else begin
                n_f[k] = EW'(18'(r_e010[k]) + interp[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_f <= n_f;
        end
    end

    // Stage 12: Lab scaling in Q16.
    assign d_xy = $signed(18'(r_f[0])) - $signed(18'(r_f[1]));
    assign d_yz = $signed(18'(r_f[1])) - $signed(18'(r_f[2]));

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_lv <= $signed(25'(r_f[1]) * 25'd116) - 25'sd1048576;
            r_av <= 27'(d_xy) * 27'sd500;
            r_bv <= 27'(d_yz) * 27'sd200;
        end
    end

    // Stage 13: round and clamp to signed Q8.8.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_lab[0] <= lcd_pkg::round_q8(27'(r_lv));
            o_lab[1] <= lcd_pkg::round_q8(r_av);
            o_lab[2] <= lcd_pkg::round_q8(r_bv);
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lcd_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_dist: squared distance of two Lab colors
// Three register stages: absolute differences, squares, rounded saturating sum.
// ----------------------------------------------------------------------------
module lcd_dist (
    input  wire logic                          i_clk,
    input  wire logic                          i_ce,
    input  wire logic signed [15:0]            i_lab_left [3],
    input  wire logic signed [15:0]            i_lab_right [3],
    output logic [lcd_pkg::DIST_W-1:0]         o_dist
);

    logic signed [16:0] diff [3];
    logic [15:0]        r_mag [3];
    logic [31:0]        r_sq [3];
    logic [33:0]        sum;
    logic [25:0]        scaled;

    // Stage 1: magnitude of each component difference.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = 17'(i_lab_left[k]) - 17'(i_lab_right[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= (diff[k] < 0) ? 16'(-diff[k]) : 16'(diff[k]);
            end
        end
    end

    // Stage 2: squares.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= 32'(r_mag[k]) * 32'(r_mag[k]);
            end
        end
    end

    // Stage 3: sum, drop eight fraction bits with rounding, saturate.
    assign sum = 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]) + 34'd128;
    assign scaled = sum[33:8];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_dist <= (scaled > 26'(lcd_pkg::DIST_MAX)) ? lcd_pkg::DIST_MAX
                                                       : scaled[24:0];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lab_color_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lab_color_distance: squared CIE76 difference of two sRGB colors
// Both colors go to L*a*b* in parallel pipelines; the distance pipeline and a
// two-entry output buffer follow.
//
//   channel  | dir | payload                                   | handshake
//   i_req    | in  | left/right red, green, blue (8 bits each) | valid/ready
//   o_res    | out | distance_squared (25 bits, 8 fraction)    | valid/ready
//
// One request per cycle enters while the pipeline is not stalled; its result
// passes the Lab stages, the distance stages and the output buffer register.
// After reset the cube root tables are built; requests are held off until then.
// The pipeline stalls as a whole only when both output buffer entries are full.
// Ready does not depend on o_res.ready in the same cycle.
// ----------------------------------------------------------------------------
module lab_color_distance #(
    parameter int CUBE_ROOT_TABLE_DEPTH = lcd_pkg::CBRT_DEPTH_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lcd_req_if.sink    i_req,
    lcd_res_if.source  o_res
);

    localparam int IDX_W = $clog2(CUBE_ROOT_TABLE_DEPTH);
    localparam int EW = lcd_pkg::TBL_ENTRY_W;
    localparam int DW = lcd_pkg::DIST_W;

    logic                 fill_done;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [2*EW-1:0]      wr_data;
    logic                 ce;
    logic                 accept;
    logic                 push;
    logic                 pop;
    logic signed [15:0]   lab_left [3];
    logic signed [15:0]   lab_right [3];
    logic [DW-1:0]        dist_out;

    logic [lcd_pkg::PIPE_DEPTH-1:0] r_vld;
    logic [1:0]           r_count, n_count;
    logic [DW-1:0]        r_buf0, n_buf0;
    logic [DW-1:0]        r_buf1, n_buf1;

    // Cube root table builder.
    lcd_cbrt_fill #(
        .CUBE_ROOT_TABLE_DEPTH (CUBE_ROOT_TABLE_DEPTH)
    ) u_fill (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_done    (fill_done),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // Pipeline advances unless the output buffer is full.
    assign ce = (r_count != 2'd2);
    assign i_req.ready = ce && fill_done;
    assign accept = i_req.valid && i_req.ready;

    lcd_lab #(
        .CUBE_ROOT_TABLE_DEPTH (CUBE_ROOT_TABLE_DEPTH)
    ) u_lab_left (
        .i_clk     (i_clk),
        .i_ce      (ce),
        .i_red     (i_req.left_red),
        .i_green   (i_req.left_green),
        .i_blue    (i_req.left_blue),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_lab     (lab_left)
    );

    lcd_lab #(
        .CUBE_ROOT_TABLE_DEPTH (CUBE_ROOT_TABLE_DEPTH)
    ) u_lab_right (
        .i_clk     (i_clk),
        .i_ce      (ce),
        .i_red     (i_req.right_red),
        .i_green   (i_req.right_green),
        .i_blue    (i_req.right_blue),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_lab     (lab_right)
    );

    lcd_dist u_dist (
        .i_clk       (i_clk),
        .i_ce        (ce),
        .i_lab_left  (lab_left),
        .i_lab_right (lab_right),
        .o_dist      (dist_out)
    );

    // Valid bits that travel with each request through the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[lcd_pkg::PIPE_DEPTH-2:0], accept};
        end
    end

    // Two-entry output buffer; entry 0 is the head.
    assign push = ce && r_vld[lcd_pkg::PIPE_DEPTH-1];
    assign pop = o_res.valid && o_res.ready;

    always_comb begin
        n_count = r_count;
        n_buf0 = r_buf0;
        n_buf1 = r_buf1;
        if (push && pop) begin
            if (r_count == 2'd1) begin
                n_buf0 = dist_out;
            end else begin
                n_buf0 = r_buf1;
                n_buf1 = dist_out;
            end
        end else if (pop) begin
            n_buf0 = r_buf1;
            n_count = r_count - 2'd1;
        end else if (push) begin
            if (r_count == 2'd0) begin
                n_buf0 = dist_out;
            end else begin
                n_buf1 = dist_out;
            end
            n_count = r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf0 <= n_buf0;
        r_buf1 <= n_buf1;
    end

    assign o_res.valid = (r_count != 2'd0);
    assign o_res.distance_squared = r_buf0;

endmodule
`default_nettype wire

### hw/rtl/lcd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_checker: port-level checks of the Lab color distance block
// Tracks requests in flight and checks the result channel against them.
// ----------------------------------------------------------------------------
module lcd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_res_valid,
    input wire logic        i_res_ready,
    input wire logic [24:0] i_res_distance
);

    localparam int MAX_OUT = lcd_pkg::PIPE_DEPTH + 2;

    logic [5:0] r_pending;
    logic       req_fire;
    logic       res_fire;

    assign req_fire = i_req_valid && i_req_ready;
    assign res_fire = i_res_valid && i_res_ready;

    // Requests accepted and not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 6'(req_fire) - 6'(res_fire);
        end
    end

    // A result is shown only for a request in flight.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (r_pending != 6'd0))
        else $error("result without an outstanding request");

    // Pipeline and buffer never hold more than their capacity.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 6'(MAX_OUT))
        else $error("more requests in flight than the pipeline holds");

    // A stalled result stays valid.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_distance))
        else $error("result changed while stalled");

endmodule

bind lab_color_distance lcd_checker u_lcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_distance (o_res.distance_squared)
);
`default_nettype wire

### tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for lab_color_distance
// Drives pairs of sRGB colors and computes the squared CIE76 distance of each
// pair in fixed point. Every returned result is compared with the oldest
// outstanding prediction. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb;

    localparam int  CBRT_DEPTH = lcd_pkg::CBRT_DEPTH_DEFAULT;
    localparam int  RANDOM_PAIRS = 2000;
    localparam int  CALM_TAIL = 200;
    localparam int  MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] lr;
        logic [7:0] lg;
        logic [7:0] lb;
        logic [7:0] rr;
        logic [7:0] rg;
        logic [7:0] rb;
        logic       drain_first;
    } t_color_pair;

    logic i_clk;
    logic i_rst_n;

    lcd_req_if req_ch();
    lcd_res_if res_ch();

    lab_color_distance dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    t_color_pair                 pending_pairs [$];
    logic [lcd_pkg::DIST_W-1:0]  distance_expected [$];
    int                          mismatch_count;
    logic                        pair_taken;
    int                          send_gap;
    int                          recv_gap;

    // sRGB byte to linear Q0.16.
    function automatic longint unsigned fifth_power(input longint unsigned w);
        longint unsigned p;
        p = (w * w) >> 30;
        p = (p * w) >> 30;
        p = (p * w) >> 30;
        p = (p * w) >> 30;
        return p;
    endfunction

    function automatic longint unsigned linearize(input logic [7:0] c);
        longint unsigned x, x2, lo, hi, mid, y, r;
        if (longint'(c) * 100000 <= 1031475) begin
            return (longint'(c) * 6553600 + 164730) / 329460;
        end
        x = ((longint'(c) * 1000 + 14025) << 30) / 269025;
        x2 = (x * x) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (fifth_power(mid) <= x2) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        y = (x2 * lo) >> 30;
        r = (y + 8192) >> 14;
        return (r > 65535) ? 65535 : r;
    endfunction

    // One cube root table entry: integer cube root of (i << 48) / depth.
    function automatic longint unsigned cbrt_segment(input longint unsigned i);
        longint unsigned v, lo, hi, mid;
        v = (i << 48) / CBRT_DEPTH;
        lo = 0;
        hi = (64'd1 << 21) - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * mid <= v) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    // Lab f(t): linear below the knee, interpolated cube root above.
    function automatic longint unsigned lab_curve(input longint unsigned t);
        longint unsigned s, idx, fr, e0, e1;
        if (t <= 580) begin
            return (7787 * t + 500) / 1000 + 9039;
        end
        if (t > 65536) t = 65536;
        s = t * CBRT_DEPTH;
        idx = s >> 16;
        fr = s & 64'hFFFF;
        e0 = cbrt_segment(idx);
        e1 = cbrt_segment(idx + 1);
        return e0 + (((e1 - e0) * fr + 32768) >> 16);
    endfunction

    // Q8 to integer, half away from zero, clamped to 16 bits.
    function automatic longint round_half_away(input longint v);
        longint r;
        if (v >= 0) begin
            r = (v + 128) >>> 8;
        end else begin
            r = -((-v + 128) >>> 8);
        end
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    typedef longint t_lab [3];

    function automatic t_lab color_to_lab(input logic [7:0] r8, input logic [7:0] g8,
                                          input logic [7:0] b8);
        longint unsigned rl, gl, bl, x, y, z;
        longint fx, fy, fz;
        t_lab lab;
        rl = linearize(r8);
        gl = linearize(g8);
        bl = linearize(b8);
        x = (27027 * rl + 23436 * gl + 11829 * bl + 32768) >> 16;
        y = (13933 * rl + 46871 * gl + 4732 * bl + 32768) >> 16;
        z = (1265 * rl + 7812 * gl + 62292 * bl + 32768) >> 16;
        x = (x * 10000 + 4752) / 9505;
        z = (z * 1000 + 544) / 1089;
        fx = longint'(lab_curve(x));
        fy = longint'(lab_curve(y));
        fz = longint'(lab_curve(z));
        lab[0] = round_half_away(116 * fy - 4096 * 256);
        lab[1] = round_half_away(500 * (fx - fy));
        lab[2] = round_half_away(200 * (fy - fz));
        return lab;
    endfunction

    function automatic logic [lcd_pkg::DIST_W-1:0] predict_distance(input t_color_pair p);
        t_lab a, b;
        longint unsigned sum, res;
        longint d;
        a = color_to_lab(p.lr, p.lg, p.lb);
        b = color_to_lab(p.rr, p.rg, p.rb);
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            d = a[k] - b[k];
            sum += longint'(d * d);
        end
        res = (sum + 128) >> 8;
        if (res > 33554431) res = 33554431;
        return res[lcd_pkg::DIST_W-1:0];
    endfunction

    function automatic t_color_pair make_pair(input int lr, input int lg, input int lb,
                                              input int rr, input int rg, input int rb);
        t_color_pair p;
        p.lr = lr[7:0];
        p.lg = lg[7:0];
        p.lb = lb[7:0];
        p.rr = rr[7:0];
        p.rg = rg[7:0];
        p.rb = rb[7:0];
        p.drain_first = 1'b0;
        return p;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Reset and stimulus build-up.
    initial begin
        t_color_pair p;
        int lr, lg, lb, mode;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.left_red = '0;
        req_ch.left_green = '0;
        req_ch.left_blue = '0;
        req_ch.right_red = '0;
        req_ch.right_green = '0;
        req_ch.right_blue = '0;
        res_ch.ready = 1'b0;

        // Directed: extremes, primaries, segment boundaries and dark colors.
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(255, 255, 255, 255, 255, 255));
        pending_pairs.push_back(make_pair(0, 0, 0, 255, 255, 255));
        pending_pairs.push_back(make_pair(255, 255, 255, 0, 0, 0));
        pending_pairs.push_back(make_pair(255, 0, 0, 0, 255, 0));
        pending_pairs.push_back(make_pair(0, 0, 255, 0, 255, 0));
        pending_pairs.push_back(make_pair(0, 0, 255, 255, 255, 0));
        pending_pairs.push_back(make_pair(255, 0, 255, 0, 255, 0));
        pending_pairs.push_back(make_pair(10, 10, 10, 11, 11, 11));
        pending_pairs.push_back(make_pair(10, 0, 0, 0, 0, 10));
        pending_pairs.push_back(make_pair(11, 0, 0, 0, 11, 0));
        pending_pairs.push_back(make_pair(1, 2, 3, 4, 5, 6));
        pending_pairs.push_back(make_pair(20, 20, 20, 0, 0, 0));
        pending_pairs.push_back(make_pair(128, 128, 128, 127, 127, 127));
        pending_pairs.push_back(make_pair(170, 85, 170, 85, 170, 85));
        pending_pairs.push_back(make_pair(0, 255, 255, 255, 0, 0));
        pending_pairs.push_back(make_pair(254, 1, 254, 1, 254, 1));

        // Random pairs: uniform, near neighbors, and dark colors.
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            mode = $urandom_range(0, 3);
            lr = $urandom_range(0, 255);
            lg = $urandom_range(0, 255);
            lb = $urandom_range(0, 255);
            if (mode == 0 || mode == 1) begin
                p = make_pair(lr, lg, lb, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255));
            end else if (mode == 2) begin
                p = make_pair(lr, lg, lb, lr + $urandom_range(0, 6) - 3,
                              lg + $urandom_range(0, 6) - 3, lb + $urandom_range(0, 6) - 3);
            end else begin
                p = make_pair($urandom_range(0, 24), $urandom_range(0, 24),
                              $urandom_range(0, 24), $urandom_range(0, 24),
                              $urandom_range(0, 24), $urandom_range(0, 24));
            end
            // Partway through, let the pipeline empty before sending on.
            p.drain_first = (n == RANDOM_PAIRS / 2);
            pending_pairs.push_back(p);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || distance_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("lab_color_distance: match");
        end else begin
            $display("lab_color_distance: mismatch");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #8000000;
        $display("lab_color_distance: mismatch");
        $finish;
    end

    // Request driver.
    always @(negedge i_clk) begin
        logic calm;
        calm = (pending_pairs.size() < CALM_TAIL);
        if (!i_rst_n) begin
            send_gap <= 0;
        end else begin
            if (pair_taken) void'(pending_pairs.pop_front());
            if (pending_pairs.size() == 0) begin
                req_ch.valid <= 1'b0;
            end else if (req_ch.valid && !pair_taken) begin
                req_ch.valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                send_gap <= $urandom_range(1, 19) - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_pairs[0].drain_first && distance_expected.size() != 0) begin
                req_ch.valid <= 1'b0;
            end else begin
                req_ch.valid <= 1'b1;
                req_ch.left_red <= pending_pairs[0].lr;
                req_ch.left_green <= pending_pairs[0].lg;
                req_ch.left_blue <= pending_pairs[0].lb;
                req_ch.right_red <= pending_pairs[0].rr;
                req_ch.right_green <= pending_pairs[0].rg;
                req_ch.right_blue <= pending_pairs[0].rb;
            end
        end
    end

    // Result ready with random stall bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            recv_gap <= 0;
            res_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            res_ch.ready <= 1'b0;
        end else if (pending_pairs.size() >= CALM_TAIL && $urandom_range(0, 15) == 0) begin
            recv_gap <= $urandom_range(1, 19) - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge i_clk) begin
        logic [lcd_pkg::DIST_W-1:0] want;
        t_color_pair p;
        if (!i_rst_n) begin
            pair_taken <= 1'b0;
            mismatch_count <= 0;
        end else begin
            pair_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready) begin
                p = pending_pairs[0];
                distance_expected.push_back(predict_distance(p));
            end
            if (res_ch.valid && res_ch.ready) begin
                if (distance_expected.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("unexpected result: distance_squared=%0d",
                                 res_ch.distance_squared);
                    end
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = distance_expected.pop_front();
                    if (res_ch.distance_squared !== want) begin
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("distance_squared: expected %0d, got %0d",
                                     want, res_ch.distance_squared);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire
